FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants for the diffusion stencil step
// Register indexes, limits, fixed-point constants and pipeline tag type.
// ----------------------------------------------------------------------------
package dss_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ABOVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_BELOW = 3'd4;

    // register widths and reset values
    localparam int FACTOR_W = 16;
    localparam int COLS_W   = 11;
    localparam int ROWS_W   = 13;

    localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd16384;
    localparam logic [COLS_W-1:0]   COLS_RST   = 11'd1024;
    localparam logic [ROWS_W-1:0]   ROWS_RST   = 13'd256;

    // grid limits
    localparam int MIN_COLS = 3;
    localparam int MAX_ROWS = 4096;

    // output tag widths
    localparam int ROW_IDX_W = 12;
    localparam int COL_IDX_W = 10;

    // Q0.16 gain: product is rounded half up before dropping 16 fraction bits
    localparam int FRAC_BITS  = 16;
    localparam int ROUND_HALF = 32768;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int OUTST_W    = 4;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_IDX_W-1:0] col_index;
        logic                 frame_end;
        logic                 pass;
    } meta_t;

endpackage

FILE: rtl/diffusion_stencil_step.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_step: five-point explicit diffusion step on a streamed slab
// Items pass S1-S3 into the result queue; one item per cycle while in_ready is high.
// Rate set by the two line-buffer RAMs (middle: 1 write, 2 reads/cycle) and 8-entry queue.
// Reset clears counters, pipeline and queue, loads register defaults; RAMs keep data.
// ----------------------------------------------------------------------------
module diffusion_stencil_step
    import dss_pkg::*;
#(
    parameter int MAX_COLS  = 1024,
    parameter int CELL_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [CELL_BITS-1:0] cell_in,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [CELL_BITS-1:0] cell_out,
    output logic [ROW_IDX_W-1:0]        row_index,
    output logic [COL_IDX_W-1:0]        col_index,
    output logic                        last_in_run,
    output logic                        frame_end
);

    localparam int CB = CELL_BITS;
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = ($clog2(MAX_COLS + 1) > COLS_W) ? $clog2(MAX_COLS + 1) : COLS_W;
    localparam int LW = CB + 3;             // laplacian
    localparam int PW = LW + FACTOR_W + 2;  // gain product plus rounding headroom
    localparam int DW = PW - FRAC_BITS;     // rounded delta
    localparam int SW = CB + 5;             // centre plus delta

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [FACTOR_W-1:0] factor_reg;
    logic [COLS_W-1:0]   cols_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic                has_above_reg;
    logic                has_below_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg    <= FACTOR_RST;
            cols_reg      <= COLS_RST;
            rows_reg      <= ROWS_RST;
            has_above_reg <= 1'b0;
            has_below_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FACTOR:    factor_reg    <= cfg_data[FACTOR_W-1:0];
                CFG_COLS:      cols_reg      <= cfg_data[COLS_W-1:0];
                CFG_ROWS:      rows_reg      <= cfg_data[ROWS_W-1:0];
                CFG_HAS_ABOVE: has_above_reg <= cfg_data[0];
                CFG_HAS_BELOW: has_below_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // position counters and per-item tags
    // ------------------------------------------------------------------
    logic [AW-1:0]     col_reg, col_next;
    logic [ROWS_W-1:0] row_reg, row_next;
    logic [OUTST_W-1:0] outst_reg;

    logic [NW-1:0]     ncols, col_ext, j_full;
    logic [ROWS_W-1:0] nrows, own;
    logic [AW-1:0]     j, j_east;
    logic              last_col, has_result, accept;
    meta_t             meta_in;

    assign in_ready = (outst_reg < OUTST_W'(FIFO_DEPTH));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (NW'(cols_reg) < NW'(MIN_COLS))
            ncols = NW'(MIN_COLS);
        else if (NW'(cols_reg) > NW'(MAX_COLS))
            ncols = NW'(MAX_COLS);
        else
            ncols = NW'(cols_reg);

        if (rows_reg == '0)
            nrows = ROWS_W'(1);
        else if (rows_reg > ROWS_W'(MAX_ROWS))
            nrows = ROWS_W'(MAX_ROWS);
        else
            nrows = rows_reg;

        col_ext  = NW'(col_reg);
        j_full   = (col_ext >= ncols) ? (ncols - NW'(1)) : col_ext;
        j        = j_full[AW-1:0];
        j_east   = j + AW'(1);
        last_col = (j_full == ncols - NW'(1));

        has_result = (row_reg >= ROWS_W'(2));
        own        = row_reg - ROWS_W'(2);

        meta_in.row_index = own[ROW_IDX_W-1:0];
        meta_in.col_index = j_full[COL_IDX_W-1:0];
        meta_in.frame_end = (own >= nrows - ROWS_W'(1)) && last_col;
        meta_in.pass      = (j_full == '0) || last_col
                            || ((own == '0) && !has_above_reg)
                            || ((own == nrows - ROWS_W'(1)) && !has_below_reg);

        if (last_col)
        begin
            col_next = '0;
            row_next = (row_reg >= nrows + ROWS_W'(1)) ? '0 : row_reg + ROWS_W'(1);
        end
        else
        begin
            col_next = j + AW'(1);
            row_next = row_reg;
        end
    end

    // ------------------------------------------------------------------
    // line buffers
    // middle holds the previous stream row, upper the one before it.
    // Upper is written in the following cycle, once the centre has been read.
    // ------------------------------------------------------------------
    logic [CB-1:0] upper_line  [MAX_COLS];
    logic [CB-1:0] middle_line [MAX_COLS];

    logic [CB-1:0] centre_rd_reg, east_rd_reg, north_rd_reg;
    logic [CB-1:0] south_s1_reg, west_s1_reg;
    logic [AW-1:0] col_s1_reg;
    logic          any_s1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            centre_rd_reg    <= middle_line[j];
            east_rd_reg      <= middle_line[j_east];
            middle_line[j]   <= cell_in;
        end
    end

    // same column twice in a row (row cut short): take the pending upper write
    always_ff @(posedge clk)
    begin
        if (accept)
            north_rd_reg <= (any_s1_reg && (col_s1_reg == j)) ? centre_rd_reg
                                                               : upper_line[j];
        if (any_s1_reg)
            upper_line[col_s1_reg] <= centre_rd_reg;
    end

    // ------------------------------------------------------------------
    // pipeline: S1 line-buffer data, S2 laplacian, S3 gain product
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    meta_t meta_s1_reg, meta_s2_reg, meta_s3_reg;

    logic signed [LW-1:0] lap_next, lap_s2_reg;
    logic signed [CB-1:0] c_s2_reg, c_s3_reg;
    logic signed [PW-1:0] prod_next, prod_s3_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            south_s1_reg <= cell_in;
            west_s1_reg  <= centre_rd_reg;   // centre of the previous item
            col_s1_reg   <= j;
            meta_s1_reg  <= meta_in;
        end
        lap_s2_reg  <= lap_next;
        c_s2_reg    <= $signed(centre_rd_reg);
        meta_s2_reg <= meta_s1_reg;
        prod_s3_reg <= prod_next;
        c_s3_reg    <= c_s2_reg;
        meta_s3_reg <= meta_s2_reg;
    end

    always_comb
    begin
        lap_next = LW'($signed(north_rd_reg)) + LW'($signed(south_s1_reg))
                 + LW'($signed(west_s1_reg)) + LW'($signed(east_rd_reg))
                 - (LW'($signed(centre_rd_reg)) <<< 2);
        prod_next = PW'(lap_s2_reg) * PW'($signed({1'b0, factor_reg}));
    end

    // S3: round half up, add centre, saturate; pass items keep the centre unchanged
    logic signed [PW-1:0] rounded;
    logic signed [DW-1:0] delta;
    logic signed [SW-1:0] sum;
    logic        [CB-1:0] result;

    always_comb
    begin
        rounded = prod_s3_reg + PW'(ROUND_HALF);
        delta   = rounded[PW-1:FRAC_BITS];
        sum     = SW'(delta) + SW'(c_s3_reg);
        if (meta_s3_reg.pass)
            result = c_s3_reg;
        else if (sum > SAT_HI)
            result = SAT_HI[CB-1:0];
        else if (sum < SAT_LO)
            result = SAT_LO[CB-1:0];
        else
            result = sum[CB-1:0];
    end

    // ------------------------------------------------------------------
    // result queue; admission is limited by outstanding results, so the
    // pipeline never stalls
    // ------------------------------------------------------------------
    logic [CB-1:0] q_cell [FIFO_DEPTH];
    meta_t         q_meta [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUTST_W-1:0] q_count_reg;
    logic pop, push;

    assign push = v3_reg;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cell[wr_ptr_reg] <= result;
            q_meta[wr_ptr_reg] <= meta_s3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            any_s1_reg  <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            outst_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            any_s1_reg <= accept;
            v1_reg     <= accept && has_result;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            q_count_reg <= q_count_reg + OUTST_W'(push) - OUTST_W'(pop);
            outst_reg   <= outst_reg + OUTST_W'(accept && has_result) - OUTST_W'(pop);
        end
    end

    assign out_valid   = (q_count_reg != '0);
    assign cell_out    = q_cell[rd_ptr_reg];
    assign row_index   = q_meta[rd_ptr_reg].row_index;
    assign col_index   = q_meta[rd_ptr_reg].col_index;
    assign frame_end   = q_meta[rd_ptr_reg].frame_end;
    assign last_in_run = 1'b1;   // one result at most per item

endmodule
